// ===== hdl/record_stack_with_key_delete_top_defines.svh =====
// ----------------------------------------------------------------------------
// Record stack assertion macros
// Shared concurrent assertion forms for the record stack RTL.
// ----------------------------------------------------------------------------
`ifndef RECORD_STACK_WITH_KEY_DELETE_TOP_DEFINES_SVH
`define RECORD_STACK_WITH_KEY_DELETE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record stack check failed");

// next-cycle implication, checked outside reset
`define RSK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record stack check failed");

`endif

// ===== hdl/rsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Record stack package
// Codes, command/status types and name helpers shared by the stack modules.
// ----------------------------------------------------------------------------
package rsk_pkg;

   localparam int NAME_CHARS = 29;
   localparam int NAME_W     = 8 * NAME_CHARS;   // 232 bits, parts 64/64/64/40
   localparam int AGE_W      = 8;
   localparam int ENTRY_W    = NAME_W + AGE_W;
   localparam int CAP_W      = 5;
   localparam int CNT_OUT_W  = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   // operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_DEL   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // result status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      IDX_HOLD = 2'd0,
      IDX_TOP  = 2'd1,
      IDX_DEC  = 2'd2,
      IDX_INC  = 2'd3
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_CLR  = 2'd3
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_PUSH  = 2'd1,
      WR_SHIFT = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic       latch_req;
      idx_op_type idx_op;
      cnt_op_type cnt_op;
      wr_sel_type wr_sel;
      logic       set_status;
      logic [1:0] status_val;
      logic       cap_pop;
      logic       rsp_load;
   } rsk_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       match;
      logic       idx_zero;
      logic       above;
   } rsk_stat_type;

   // zero every byte from the first zero byte on
   function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] name);
      logic              ended;
      logic [NAME_W-1:0] res;
      ended = 1'b0;
      res   = '0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (name[8*i +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         res[8*i +: 8] = ended ? 8'd0 : name[8*i +: 8];
      end
      return res;
   endfunction

endpackage

// ===== hdl/rsk_req_if.sv =====
// ----------------------------------------------------------------------------
// Record stack request channel
// Valid/ready channel carrying one operation and its record.
// ----------------------------------------------------------------------------
interface rsk_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] name_part0;
   logic [63:0] name_part1;
   logic [63:0] name_part2;
   logic [39:0] name_part3;
   logic [7:0]  age_in;

   modport source (output valid, op, name_part0, name_part1, name_part2, name_part3,
                   age_in, input ready);
   modport sink   (input valid, op, name_part0, name_part1, name_part2, name_part3,
                   age_in, output ready);
endinterface

// ===== hdl/rsk_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Record stack response channel
// Valid/ready channel carrying one result beat per operation.
// ----------------------------------------------------------------------------
interface rsk_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] out_name_part0;
   logic [63:0] out_name_part1;
   logic [63:0] out_name_part2;
   logic [39:0] out_name_part3;
   logic [7:0]  age_out;
   logic [4:0]  entry_count;

   modport source (output valid, status, out_name_part0, out_name_part1, out_name_part2,
                   out_name_part3, age_out, entry_count, input ready);
   modport sink   (input valid, status, out_name_part0, out_name_part1, out_name_part2,
                   out_name_part3, age_out, entry_count, output ready);
endinterface

// ===== hdl/rsk_dpath.sv =====
// ----------------------------------------------------------------------------
// Record stack datapath
// Record memory, count, scan index, key compare and result register.
// ----------------------------------------------------------------------------
`include "record_stack_with_key_delete_top_defines.svh"

module rsk_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rsk_pkg::CAP_W-1:0]    csr_wr_data,
   input  logic [1:0]                   req_op,
   input  logic [rsk_pkg::NAME_W-1:0]   req_name,
   input  logic [rsk_pkg::AGE_W-1:0]    req_age,
   input  rsk_pkg::rsk_cmd_type         cmd,
   output rsk_pkg::rsk_stat_type        stat,
   output logic [1:0]                   rsp_status,
   output logic [rsk_pkg::NAME_W-1:0]   rsp_name,
   output logic [rsk_pkg::AGE_W-1:0]    rsp_age,
   output logic [rsk_pkg::CNT_OUT_W-1:0] rsp_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > rsk_pkg::CAP_W) ? CW : rsk_pkg::CAP_W;

   logic [rsk_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [rsk_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [rsk_pkg::ENTRY_W-1:0] wr_data;

   logic [rsk_pkg::CAP_W-1:0]   cap_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [1:0]                  op_ff;
   logic [rsk_pkg::NAME_W-1:0]  name_ff;
   logic [rsk_pkg::AGE_W-1:0]   age_ff;
   logic [rsk_pkg::NAME_W-1:0]  key_ff;
   logic [1:0]                  status_ff;
   logic [rsk_pkg::NAME_W-1:0]  res_name_ff;
   logic [rsk_pkg::AGE_W-1:0]   res_age_ff;
   logic [1:0]                  rsp_status_ff;
   logic [rsk_pkg::NAME_W-1:0]  rsp_name_ff;
   logic [rsk_pkg::AGE_W-1:0]   rsp_age_ff;
   logic [rsk_pkg::CNT_OUT_W-1:0] rsp_count_ff;

   logic [LW-1:0] cap_ext, limit, count_ext;

   // effective limit is min(capacity, DEPTH)
   always_comb begin
      cap_ext   = LW'(cap_ff);
      limit     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
      count_ext = LW'(count_ff);
   end

   always_comb begin
      stat.op       = op_ff;
      stat.full     = count_ext >= limit;
      stat.empty    = count_ff == '0;
      stat.match    = rsk_pkg::canon_name(rd_data_ff[rsk_pkg::NAME_W-1:0]) == key_ff;
      stat.idx_zero = idx_ff == '0;
      stat.above    = (CW'(idx_ff) + CW'(1)) < count_ff;
   end

   always_comb begin
      case (cmd.idx_op)
         rsk_pkg::IDX_TOP: idx_in = IW'(count_ff - CW'(1));
         rsk_pkg::IDX_DEC: idx_in = idx_ff - IW'(1);
         rsk_pkg::IDX_INC: idx_in = idx_ff + IW'(1);
         default:          idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         rsk_pkg::CNT_INC: count_in = count_ff + CW'(1);
         rsk_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         rsk_pkg::CNT_CLR: count_in = '0;
         default:          count_in = count_ff;
      endcase
   end

   // push writes at the count; a shift copies entry idx down to idx-1
   always_comb begin
      case (cmd.wr_sel)
         rsk_pkg::WR_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[IW-1:0];
            wr_data = {age_ff, name_ff};
         end
         rsk_pkg::WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - IW'(1);
            wr_data = rd_data_ff;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= rsk_pkg::CAP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch_req) begin
         op_ff       <= req_op;
         name_ff     <= req_name;
         age_ff      <= req_age;
         key_ff      <= rsk_pkg::canon_name(req_name);
         res_name_ff <= '0;
         res_age_ff  <= '0;
      end else if (cmd.cap_pop) begin
         res_name_ff <= rd_data_ff[rsk_pkg::NAME_W-1:0];
         res_age_ff  <= rd_data_ff[rsk_pkg::ENTRY_W-1 -: rsk_pkg::AGE_W];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_name_ff   <= res_name_ff;
         rsp_age_ff    <= res_age_ff;
         rsp_count_ff  <= count_ext[rsk_pkg::CNT_OUT_W-1:0];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_name   = rsp_name_ff;
   assign rsp_age    = rsp_age_ff;
   assign rsp_count  = rsp_count_ff;

   `RSK_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `RSK_ASSERT_IMP(a_push_room, clock, reset, cmd.wr_sel == rsk_pkg::WR_PUSH,
                   count_ext < limit)
   `RSK_ASSERT_IMP(a_shift_src, clock, reset, cmd.wr_sel == rsk_pkg::WR_SHIFT,
                   (CW'(idx_ff) < count_ff) && (idx_ff != '0))
   `RSK_ASSERT_NXT(a_count_inc, clock, reset, cmd.cnt_op == rsk_pkg::CNT_INC,
                   count_ff == $past(count_ff) + CW'(1))

endmodule

// ===== hdl/rsk_ctrl.sv =====
// ----------------------------------------------------------------------------
// Record stack controller
// Sequences push, pop, delete scan/shift and clear; owns the response valid.
// ----------------------------------------------------------------------------
module rsk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsk_pkg::rsk_stat_type stat,
   output rsk_pkg::rsk_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_POPRD = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.idx_op     = rsk_pkg::IDX_HOLD;
      cmd.cnt_op     = rsk_pkg::CNT_HOLD;
      cmd.wr_sel     = rsk_pkg::WR_NONE;
      cmd.status_val = rsk_pkg::ST_DONE;
      req_ready      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            case (stat.op)
               rsk_pkg::OP_PUSH: begin
                  if (stat.full) begin
                     cmd.status_val = rsk_pkg::ST_FULL;
                  end else begin
                     cmd.wr_sel = rsk_pkg::WR_PUSH;
                     cmd.cnt_op = rsk_pkg::CNT_INC;
                  end
                  state_in = S_RESP;
               end
               rsk_pkg::OP_POP: begin
                  if (stat.empty) begin
                     cmd.status_val = rsk_pkg::ST_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     cmd.idx_op = rsk_pkg::IDX_TOP;
                     cmd.cnt_op = rsk_pkg::CNT_DEC;
                     state_in   = S_POPRD;
                  end
               end
               rsk_pkg::OP_DEL: begin
                  if (stat.empty) begin
                     cmd.status_val = rsk_pkg::ST_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     cmd.idx_op = rsk_pkg::IDX_TOP;
                     state_in   = S_SCAN;
                  end
               end
               default: begin
                  cmd.cnt_op = rsk_pkg::CNT_CLR;
                  state_in   = S_RESP;
               end
            endcase
         end
         S_POPRD: begin
            cmd.cap_pop = 1'b1;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            if (stat.match) begin
               if (stat.above) begin
                  cmd.idx_op = rsk_pkg::IDX_INC;
                  state_in   = S_SHIFT;
               end else begin
                  cmd.cnt_op = rsk_pkg::CNT_DEC;
                  state_in   = S_RESP;
               end
            end else if (stat.idx_zero) begin
               cmd.set_status = 1'b1;
               cmd.status_val = rsk_pkg::ST_NOTFOUND;
               state_in       = S_RESP;
            end else begin
               cmd.idx_op = rsk_pkg::IDX_DEC;
            end
         end
         S_SHIFT: begin
            cmd.wr_sel = rsk_pkg::WR_SHIFT;
            if (stat.above) begin
               cmd.idx_op = rsk_pkg::IDX_INC;
            end else begin
               cmd.cnt_op = rsk_pkg::CNT_DEC;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/record_stack_with_key_delete_top.sv =====
// ----------------------------------------------------------------------------
// Record stack with delete by key
// Bounded LIFO of name/age records: push, pop, delete by name, clear.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | beat contents
//  ---------+-----+-------------------+------------------------------------------
//  req_bus  | in  | valid/ready       | op, name_part0..3, age_in
//  rsp_bus  | out | valid/ready       | status, out_name_part0..3, age_out,
//           |     |                   | entry_count
//  csr      | in  | csr_wr_en         | csr_wr_data = capacity_limit
//
//  Every op goes from accept through an execute state to its result; pop adds
//  a read state, and delete scans down from the top entry and then moves the
//  entries above the match down, using the single read port of the record memory.
//  Reset (synchronous, high) empties the stack and sets the capacity to 10;
//  record memory contents are not cleared, so no clearing pass is needed.
//  One op is in flight at a time; a result beat held by rsp stall does not
//  block the next request from being taken.
// ----------------------------------------------------------------------------
module record_stack_with_key_delete_top #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   rsk_req_if.sink                   req_bus,
   rsk_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [rsk_pkg::CAP_W-1:0] csr_wr_data
);

   rsk_pkg::rsk_cmd_type  cmd;
   rsk_pkg::rsk_stat_type stat;

   logic [rsk_pkg::NAME_W-1:0] req_name;
   logic [rsk_pkg::NAME_W-1:0] rsp_name;

   // name packed low part first: byte i of the name sits at bits 8*i+7:8*i
   assign req_name = {req_bus.name_part3, req_bus.name_part2,
                      req_bus.name_part1, req_bus.name_part0};

   rsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsk_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_bus.op),
      .req_name    (req_name),
      .req_age     (req_bus.age_in),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_bus.status),
      .rsp_name    (rsp_name),
      .rsp_age     (rsp_bus.age_out),
      .rsp_count   (rsp_bus.entry_count)
   );

   // unpack result name into the four beat fields
   assign rsp_bus.out_name_part0 = rsp_name[63:0];
   assign rsp_bus.out_name_part1 = rsp_name[127:64];
   assign rsp_bus.out_name_part2 = rsp_name[191:128];
   assign rsp_bus.out_name_part3 = rsp_name[231:192];

endmodule
